FILE: src/kfu_pkg.sv
// kfu_pkg: shared types and constants for the keyed fifo with update unit
// depends on nothing; used by kfu_cell and keyed_fifo_with_update_unit
package kfu_pkg;

    localparam int DEPTH  = 16;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 3;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    localparam logic [STAT_W-1:0] ST_APPENDED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd5;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [KEY_W-1:0]        out_key;
        logic signed [VAL_W-1:0] out_value;
        logic [CNT_W-1:0]        occupancy;
    } t_out;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cell_data;

    typedef struct packed {
        logic             pop;
        logic             upd;
        logic             app;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

FILE: src/kfu_cell.sv
// kfu_cell: one queue slot holding a key, a value and a valid bit
// shifts toward the head on pop; depends on kfu_pkg
module kfu_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kfu_pkg::t_cell_cmd  i_cmd,
    input  logic                i_prev_valid,
    input  kfu_pkg::t_cell_data i_next,
    output kfu_pkg::t_cell_data o_data,
    output logic                o_match
);

    logic                    r_valid;
    logic                    n_valid;
    logic [kfu_pkg::KEY_W-1:0] r_key;
    logic [kfu_pkg::KEY_W-1:0] n_key;
    logic [kfu_pkg::VAL_W-1:0] r_value;
    logic [kfu_pkg::VAL_W-1:0] n_value;

    assign o_match = r_valid && (r_key == i_cmd.key);
    assign o_data  = '{valid: r_valid, key: r_key, value: r_value};

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_value = r_value;
        if (i_cmd.pop) begin
            n_valid = i_next.valid;
            n_key   = i_next.key;
            n_value = i_next.value;
        end else if (i_cmd.app && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_key   = i_cmd.key;
            n_value = i_cmd.value;
        end else if (i_cmd.upd && o_match) begin
            n_value = i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

endmodule

FILE: src/keyed_fifo_with_update_unit.sv
// keyed_fifo_with_update_unit: queue of unique keys with in-place value update
// row of kfu_cell slots, oldest entry in slot zero; depends on kfu_pkg, kfu_cell
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (op, key, value)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (status, key, value, occupancy)
//
// one transaction per cycle while results are taken; the result appears in the cycle after acceptance
// every slot compares its key in parallel, a pop shifts all slots by one
// a result waiting in the output register does not block the next transaction
// if it is taken in the same cycle; otherwise o_in_ready drops
// synchronous active-low reset empties the queue; no clearing pass
module keyed_fifo_with_update_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  kfu_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output kfu_pkg::t_out o_out_data
);

    kfu_pkg::t_cell_data               w_cell [kfu_pkg::DEPTH];
    logic [kfu_pkg::DEPTH-1:0]         w_match;
    logic [kfu_pkg::DEPTH-1:0]         w_valid_vec;
    kfu_pkg::t_cell_cmd                w_cmd;
    logic                              w_accept;
    logic                              w_is_find;
    logic                              w_is_remove;
    logic                              w_is_insert;
    logic                              w_hit;
    logic                              w_full;
    logic                              w_empty;
    logic [kfu_pkg::VAL_W-1:0]         w_found_value;

    logic [kfu_pkg::CNT_W-1:0]         r_count;
    logic [kfu_pkg::CNT_W-1:0]         n_count;
    logic                              r_out_valid;
    kfu_pkg::t_out                     r_out;
    kfu_pkg::t_out                     n_out;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // op code 3 decodes as find
    assign w_is_find   = i_in_data.op[1];
    assign w_is_remove = !i_in_data.op[1] && (i_in_data.op == kfu_pkg::OP_REMOVE);
    assign w_is_insert = (i_in_data.op == kfu_pkg::OP_INSERT);

    assign w_hit   = |w_match;
    assign w_full  = (r_count == kfu_pkg::CNT_W'(kfu_pkg::DEPTH));
    assign w_empty = (r_count == '0);

    assign w_cmd.pop   = w_accept && w_is_remove && !w_empty;
    assign w_cmd.upd   = w_accept && w_is_insert && w_hit;
    assign w_cmd.app   = w_accept && w_is_insert && !w_hit && !w_full;
    assign w_cmd.key   = i_in_data.key;
    assign w_cmd.value = i_in_data.value;

    genvar g;
    generate
        for (g = 0; g < kfu_pkg::DEPTH; g++) begin : g_cell
            logic                w_prev_valid;
            kfu_pkg::t_cell_data w_next;
            if (g == 0) begin : g_first
                assign w_prev_valid = 1'b1;
            end else begin : g_rest
                assign w_prev_valid = w_cell[g-1].valid;
            end
            if (g == kfu_pkg::DEPTH - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_inner
                assign w_next = w_cell[g+1];
            end
            kfu_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_prev_valid (w_prev_valid),
                .i_next       (w_next),
                .o_data       (w_cell[g]),
                .o_match      (w_match[g])
            );
            assign w_valid_vec[g] = w_cell[g].valid;
        end
    endgenerate

    always_comb begin
        w_found_value = '0;
        for (int i = 0; i < kfu_pkg::DEPTH; i++) begin
            w_found_value = w_found_value | (w_match[i] ? w_cell[i].value : '0);
        end
    end

    always_comb begin
        n_count           = r_count;
        n_out.status      = kfu_pkg::ST_NOT_FOUND;
        n_out.out_key     = i_in_data.key;
        n_out.out_value   = '0;
        if (w_is_find) begin
            if (w_hit) begin
                n_out.status    = kfu_pkg::ST_FOUND;
                n_out.out_value = w_found_value;
            end
        end else if (w_is_remove) begin
            if (w_empty) begin
                n_out.status = kfu_pkg::ST_EMPTY;
            end else begin
                n_out.status    = kfu_pkg::ST_REMOVED;
                n_out.out_key   = w_cell[0].key;
                n_out.out_value = w_cell[0].value;
                n_count         = r_count - kfu_pkg::CNT_W'(1);
            end
        end else begin
            if (w_hit) begin
                n_out.status = kfu_pkg::ST_UPDATED;
            end else if (w_full) begin
                n_out.status = kfu_pkg::ST_FULL;
            end else begin
                n_out.status = kfu_pkg::ST_APPENDED;
                n_count      = r_count + kfu_pkg::CNT_W'(1);
            end
        end
        n_out.occupancy = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    a_count_matches_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == 32'(r_count))
        else $error("slot valid bits disagree with entry count");

    a_keys_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("key matched in more than one slot");

    a_occupancy_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.occupancy == r_count))
        else $error("reported occupancy differs from entry count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == kfu_pkg::ST_FULL))
            |-> (o_out_data.occupancy == kfu_pkg::CNT_W'(kfu_pkg::DEPTH)))
        else $error("full status with free slots");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |=> (r_count == $past(r_count) - kfu_pkg::CNT_W'(1)))
        else $error("pop did not reduce entry count");

endmodule
